// ===== src/mdcd_pkg.sv =====
package mdcd_pkg;

  localparam int unsigned ACCUM_WIDTH_DEF = 32;
  localparam int unsigned INT_SHIFT       = 16;
  localparam int unsigned DITHER_MAX_BITS = 16;

  localparam logic [31:0] SEED_DEFAULT      = 32'h0000_ACE1;
  localparam logic [15:0] DIV_INT_RESET     = 16'd8;
  localparam logic [4:0]  DITHER_BITS_RESET = 5'd4;

  // config register indexes
  typedef enum logic [2:0] {
    CFG_PHASE_STEP   = 3'd0,
    CFG_DIV_INT      = 3'd1,
    CFG_DIV_FRAC     = 3'd2,
    CFG_SECOND_ORDER = 3'd3,
    CFG_DITHER_ON    = 3'd4,
    CFG_DITHER_BITS  = 3'd5,
    CFG_SEED         = 3'd6
  } cfg_reg_t;

  // per-item control into the modulator
  typedef struct packed {
    logic fire;
    logic restart;
    logic second_order;
  } mash_ctrl_t;

  // xorshift32, shifts 13 / 17 / 5
  function automatic logic [31:0] xorshift32(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

endpackage

// ===== src/mdcd_dither.sv =====
module mdcd_dither
  import mdcd_pkg::*;
#(
  parameter int unsigned ACCUM_WIDTH = ACCUM_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  logic                   dither_on,
  input  logic [4:0]             dither_bits,
  input  logic [31:0]            phase_step,
  input  logic                   seed_load,
  input  logic [31:0]            seed_value,
  output logic [ACCUM_WIDTH-1:0] step,
  output logic [31:0]            rng_state
);

  logic [31:0]                   rng_r;
  logic [31:0]                   rng_nxt;
  logic [4:0]                    b_cl;
  logic [DITHER_MAX_BITS-1:0]    rmask;
  logic [DITHER_MAX_BITS-1:0]    r;
  logic [DITHER_MAX_BITS-1:0]    half;
  logic signed [DITHER_MAX_BITS:0]  d;
  logic signed [ACCUM_WIDTH-1:0] d_ext;
  logic [ACCUM_WIDTH-1:0]        step_base;

  assign rng_nxt = xorshift32(rng_r);

  always_comb begin
    if (dither_bits == 5'd0) begin
      b_cl = 5'd1;
    end else if (dither_bits > 5'(DITHER_MAX_BITS)) begin
      b_cl = 5'(DITHER_MAX_BITS);
    end else begin
      b_cl = dither_bits;
    end
  end

  assign rmask     = DITHER_MAX_BITS'(({(DITHER_MAX_BITS+1){1'b0}} | 1'b1) << b_cl) - 1'b1;
  assign r         = rng_nxt[DITHER_MAX_BITS-1:0] & rmask;
  assign half      = DITHER_MAX_BITS'(1) << (b_cl - 5'd1);
  assign d         = $signed({1'b0, r}) - $signed({1'b0, half});
  assign d_ext     = ACCUM_WIDTH'(d);
  assign step_base = ACCUM_WIDTH'(phase_step);

  // r == 0 would be minus half: forced to no dither
  assign step = (dither_on && (r != '0)) ? step_base + ACCUM_WIDTH'(d_ext) : step_base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rng_r <= SEED_DEFAULT;
    end else if (seed_load) begin
      rng_r <= (seed_value != 32'd0) ? seed_value : SEED_DEFAULT;
    end else if (fire && dither_on) begin
      rng_r <= rng_nxt;
    end
  end

  assign rng_state = rng_r;

endmodule

// ===== src/mdcd_mash.sv =====
module mdcd_mash
  import mdcd_pkg::*;
#(
  parameter int unsigned ACCUM_WIDTH = ACCUM_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mash_ctrl_t             ctrl,
  input  logic [ACCUM_WIDTH-1:0] step,
  output logic signed [2:0]      corr
);

  logic [ACCUM_WIDTH-1:0] first_r;
  logic [ACCUM_WIDTH-1:0] second_r;
  logic                   prev_carry_r;
  logic [ACCUM_WIDTH-1:0] a1;
  logic [ACCUM_WIDTH-1:0] a2;
  logic                   pc;
  logic [ACCUM_WIDTH:0]   s1;
  logic [ACCUM_WIDTH:0]   s2;
  logic                   c1;
  logic                   c2;

  // restart clears both accumulators and the held carry ahead of the step
  assign a1 = ctrl.restart ? '0 : first_r;
  assign a2 = ctrl.restart ? '0 : second_r;
  assign pc = ctrl.restart ? 1'b0 : prev_carry_r;

  assign s1 = {1'b0, a1} + {1'b0, step};
  assign c1 = s1[ACCUM_WIDTH];
  assign s2 = {1'b0, a2} + {1'b0, s1[ACCUM_WIDTH-1:0]};
  assign c2 = s2[ACCUM_WIDTH];

  always_comb begin
    if (ctrl.second_order) begin
      corr = $signed({2'b00, c1}) + $signed({2'b00, c2}) - $signed({2'b00, pc});
    end else begin
      corr = $signed({2'b00, c1});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r      <= '0;
      second_r     <= '0;
      prev_carry_r <= 1'b0;
    end else if (ctrl.fire) begin
      first_r <= s1[ACCUM_WIDTH-1:0];
      if (ctrl.second_order) begin
        second_r     <= s2[ACCUM_WIDTH-1:0];
        prev_carry_r <= c2;
      end else begin
        second_r     <= a2;
        prev_carry_r <= pc;
      end
    end
  end

endmodule

// ===== src/mdcd_divcorr.sv =====
module mdcd_divcorr
  import mdcd_pkg::*;
(
  input  logic [15:0]       div_int,
  input  logic [7:0]        div_frac,
  input  logic signed [2:0] corr,
  output logic [15:0]       int_out,
  output logic [7:0]        frac_out,
  output logic [31:0]       clkdiv_word
);

  logic signed [9:0] sum;

  assign sum      = $signed({2'b00, div_frac}) + 10'(corr);
  assign frac_out = sum[7:0];

  // carry into / borrow from the integer part, wraps mod 2^16
  always_comb begin
    if (sum[9]) begin
      int_out = div_int - 16'd1;
    end else if (sum[8]) begin
      int_out = div_int + 16'd1;
    end else begin
      int_out = div_int;
    end
  end

  assign clkdiv_word = (32'(int_out) << INT_SHIFT) | (32'(frac_out) << 8);

endmodule

// ===== src/mash_dither_clock_divider.sv =====
// MASH sigma-delta fractional divider with optional xorshift dither. Every
// accepted item (one tick) runs one first- or second-order modulator step and
// yields one result item: the corrected 16.8 divider and its packed word.
// Throughput is one item per clock while the output is not stalled; an item
// passes through the input register, then the accumulator/dither chain into
// the result register, where out_valid marks it ready to be taken.
// That rate is set by the accumulator loop:
// dither add, first accumulator add, second accumulator add. Config writes
// are always taken (cfg_ready tied high) and must only happen while the
// block is idle; writing the seed register reloads the generator, with zero
// mapped to 0xACE1. A restart item clears both accumulators and the held
// carry but leaves the generator running.
module mash_dither_clock_divider
  import mdcd_pkg::*;
#(
  parameter int unsigned ACCUM_WIDTH = ACCUM_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // item in
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_restart,
  // item out
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       out_int_out,
  output logic [7:0]        out_frac_out,
  output logic signed [2:0] out_correction,
  output logic [31:0]       out_clkdiv_word,
  // config writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  // config registers
  logic [31:0] phase_step_r;
  logic [15:0] div_int_r;
  logic [7:0]  div_frac_r;
  logic        second_order_r;
  logic        dither_on_r;
  logic [4:0]  dither_bits_r;
  logic        cfg_fire;
  logic        seed_load;

  // pipeline
  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic        s1_restart_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        out_load;
  logic        s1_adv;
  logic        in_accept;

  logic [15:0]       int_out_r;
  logic [7:0]        frac_out_r;
  logic signed [2:0] correction_r;
  logic [31:0]       clkdiv_word_r;

  logic [ACCUM_WIDTH-1:0] step;
  logic [31:0]            rng_state;
  mash_ctrl_t             mash_ctrl;
  logic signed [2:0]      corr;
  logic [15:0]            int_c;
  logic [7:0]             frac_c;
  logic [31:0]            word_c;

  // --- config port ---
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign seed_load = cfg_fire && (cfg_reg_t'(cfg_index) == CFG_SEED);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r   <= 32'd0;
      div_int_r      <= DIV_INT_RESET;
      div_frac_r     <= 8'd0;
      second_order_r <= 1'b0;
      dither_on_r    <= 1'b0;
      dither_bits_r  <= DITHER_BITS_RESET;
    end else if (cfg_fire) begin
      case (cfg_reg_t'(cfg_index))
        CFG_PHASE_STEP:   phase_step_r   <= cfg_data;
        CFG_DIV_INT:      div_int_r      <= cfg_data[15:0];
        CFG_DIV_FRAC:     div_frac_r     <= cfg_data[7:0];
        CFG_SECOND_ORDER: second_order_r <= cfg_data[0];
        CFG_DITHER_ON:    dither_on_r    <= cfg_data[0];
        CFG_DITHER_BITS:  dither_bits_r  <= cfg_data[4:0];
        default: ;  // seed goes to the generator; unused index ignored
      endcase
    end
  end

  // --- handshake: input register -> result register ---
  // result register reloads when empty or being taken
  assign out_load  = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && out_load;
  assign in_stall  = s1_valid_r && !out_load;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_comb begin
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_load) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_restart_r <= in_restart;
    end
  end

  // --- datapath ---
  mdcd_dither #(
    .ACCUM_WIDTH (ACCUM_WIDTH)
  ) u_dither (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (s1_adv),
    .dither_on   (dither_on_r),
    .dither_bits (dither_bits_r),
    .phase_step  (phase_step_r),
    .seed_load   (seed_load),
    .seed_value  (cfg_data),
    .step        (step),
    .rng_state   (rng_state)
  );

  assign mash_ctrl.fire         = s1_adv;
  assign mash_ctrl.restart      = s1_restart_r;
  assign mash_ctrl.second_order = second_order_r;

  mdcd_mash #(
    .ACCUM_WIDTH (ACCUM_WIDTH)
  ) u_mash (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mash_ctrl),
    .step  (step),
    .corr  (corr)
  );

  mdcd_divcorr u_divcorr (
    .div_int     (div_int_r),
    .div_frac    (div_frac_r),
    .corr        (corr),
    .int_out     (int_c),
    .frac_out    (frac_c),
    .clkdiv_word (word_c)
  );

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      int_out_r     <= int_c;
      frac_out_r    <= frac_c;
      correction_r  <= corr;
      clkdiv_word_r <= word_c;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_int_out     = int_out_r;
  assign out_frac_out    = frac_out_r;
  assign out_correction  = correction_r;
  assign out_clkdiv_word = clkdiv_word_r;

  // --- checks ---
  // correction only ever spans -1..2
  a_corr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_correction != 3'sb100) && (out_correction != 3'sb101) &&
                  (out_correction != 3'sb110))
    else $error("correction out of range");

  // packed word agrees with the separate fields
  a_word_pack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_clkdiv_word[31:16] == out_int_out) &&
                  (out_clkdiv_word[15:8] == out_frac_out) &&
                  (out_clkdiv_word[7:0] == 8'd0))
    else $error("packed divider word mismatch");

  // back-pressure only while an item is held in the input register and the result register is full
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("stall without held item");

  // generator never reaches the all-zero lock-up state
  a_rng_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    rng_state != 32'd0)
    else $error("generator stuck at zero");

endmodule
